[design/bleap_pkg.sv]
package bleap_pkg;

	// Parser phases
	localparam logic [3:0] PH_WAIT     = 4'd0;
	localparam logic [3:0] PH_ADVTYPE  = 4'd1;
	localparam logic [3:0] PH_ADDRTYPE = 4'd2;
	localparam logic [3:0] PH_ADDR     = 4'd3;
	localparam logic [3:0] PH_DATALEN  = 4'd4;
	localparam logic [3:0] PH_ADLEN    = 4'd5;
	localparam logic [3:0] PH_ADTYPE   = 4'd6;
	localparam logic [3:0] PH_PAYLOAD  = 4'd7;
	localparam logic [3:0] PH_RSSI     = 4'd8;

	// Field kinds on the result channel
	localparam logic [3:0] KIND_COUNT    = 4'd0;
	localparam logic [3:0] KIND_ADVTYPE  = 4'd1;
	localparam logic [3:0] KIND_ADDRTYPE = 4'd2;
	localparam logic [3:0] KIND_ADDR     = 4'd3;
	localparam logic [3:0] KIND_DATALEN  = 4'd4;
	localparam logic [3:0] KIND_ADLEN    = 4'd5;
	localparam logic [3:0] KIND_ADTYPE   = 4'd6;
	localparam logic [3:0] KIND_PAYLOAD  = 4'd7;
	localparam logic [3:0] KIND_TXPOWER  = 4'd8;
	localparam logic [3:0] KIND_NAMECHAR = 4'd9;
	localparam logic [3:0] KIND_RSSI     = 4'd10;

	// Error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_COUNT      = 2'd1;
	localparam logic [1:0] ERR_ZERO_ADLEN = 2'd2;
	localparam logic [1:0] ERR_AD_OVERRUN = 2'd3;

	// AD types and limits
	localparam logic [7:0] AD_TYPE_TXPOWER   = 8'h0a;
	localparam logic [7:0] AD_TYPE_NAME      = 8'h09;
	localparam logic [6:0] AD_INDEX_MAX      = 7'd127;
	localparam logic [2:0] ADDR_LAST         = 3'd5;
	localparam logic [7:0] MAX_REPORTS_RESET = 8'h19;

	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] reports_left;
		logic [7:0] report_number;
		logic [2:0] addr_count;
		logic [7:0] data_left;
		logic [7:0] ad_left;
		logic [7:0] ad_type;
		logic [6:0] ad_number;
		logic [7:0] pay_off;
	} parse_state_t;

	typedef struct packed {
		logic       has_result;
		logic [3:0] kind;
		logic [7:0] value;
		logic [7:0] rep;
		logic [6:0] adi;
		logic [7:0] off;
		logic       done;
		logic [1:0] err;
	} parse_result_t;

endpackage

[design/bleap_in_stage.sv]
module bleap_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       advance,
	output logic       vld_s1,
	output logic [7:0] data_s1,
	output logic       first_s1
);
	// The stage takes a new byte whenever it is empty or drains this cycle.
	assign in_ready = !vld_s1 || advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end
endmodule

[design/bleap_step.sv]
module bleap_step (
	input  bleap_pkg::parse_state_t  st,
	input  logic [7:0]               data,
	input  logic                     first,
	input  logic [7:0]               max_reports,
	output bleap_pkg::parse_state_t  st_next,
	output bleap_pkg::parse_result_t res
);
	import bleap_pkg::*;

	logic [7:0] dl_dec;
	logic [7:0] al_dec;
	logic [7:0] al_new;
	logic [6:0] adn_inc;

	assign dl_dec  = st.data_left - 8'd1;
	assign al_dec  = st.ad_left - 8'd1;
	assign adn_inc = (st.ad_number < AD_INDEX_MAX) ? st.ad_number + 7'd1 : st.ad_number;

	// Length of an AD entry, cut to the data bytes left after its length byte.
	assign al_new = (data > dl_dec) ? dl_dec : data;

	// One parsing step for the byte in the input register.
	always_comb begin
		st_next        = st;
		res.has_result = 1'b1;
		res.kind       = KIND_COUNT;
		res.value      = data;
		res.rep        = st.report_number;
		res.adi        = 7'd0;
		res.off        = 8'd0;
		res.done       = 1'b0;
		res.err        = ERR_NONE;

		if (first) begin
			// A count byte always opens a new event.
			res.rep              = 8'd0;
			st_next.reports_left  = data;
			st_next.report_number = 8'd0;
			if (data == 8'd0 || data > max_reports) begin
				res.err = ERR_COUNT;
			end
			if (data == 8'd0) begin
				res.done      = 1'b1;
				st_next.phase = PH_WAIT;
			end else begin
				st_next.phase = PH_ADVTYPE;
			end
		end else begin
			case (st.phase)
				PH_ADVTYPE: begin
					res.kind      = KIND_ADVTYPE;
					st_next.phase = PH_ADDRTYPE;
				end
				PH_ADDRTYPE: begin
					res.kind           = KIND_ADDRTYPE;
					st_next.addr_count = 3'd0;
					st_next.phase      = PH_ADDR;
				end
				PH_ADDR: begin
					res.kind = KIND_ADDR;
					res.off  = {5'd0, st.addr_count};
					if (st.addr_count >= ADDR_LAST) begin
						st_next.addr_count = 3'd0;
						st_next.phase      = PH_DATALEN;
					end else begin
						st_next.addr_count = st.addr_count + 3'd1;
					end
				end
				PH_DATALEN: begin
					res.kind          = KIND_DATALEN;
					st_next.data_left = data;
					st_next.ad_number = 7'd0;
					st_next.phase     = (data == 8'd0) ? PH_RSSI : PH_ADLEN;
				end
				PH_ADLEN: begin
					res.kind          = KIND_ADLEN;
					res.adi           = st.ad_number;
					st_next.data_left = dl_dec;
					if (data == 8'd0) begin
						res.err = ERR_ZERO_ADLEN;
					end else if (data > dl_dec) begin
						res.err = ERR_AD_OVERRUN;
					end
					st_next.ad_left = al_new;
					if (al_new == 8'd0) begin
						// Empty entry: move to the next entry or to the RSSI byte.
						if (dl_dec == 8'd0) begin
							st_next.phase = PH_RSSI;
						end else begin
							st_next.phase     = PH_ADLEN;
							st_next.ad_number = adn_inc;
						end
					end else begin
						st_next.phase = PH_ADTYPE;
					end
				end
				PH_ADTYPE: begin
					res.kind          = KIND_ADTYPE;
					res.adi           = st.ad_number;
					st_next.ad_type   = data;
					st_next.ad_left   = al_dec;
					st_next.data_left = dl_dec;
					st_next.pay_off   = 8'd0;
					if (al_dec == 8'd0) begin
						if (dl_dec == 8'd0) begin
							st_next.phase = PH_RSSI;
						end else begin
							st_next.phase     = PH_ADLEN;
							st_next.ad_number = adn_inc;
						end
					end else begin
						st_next.phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (st.ad_type == AD_TYPE_TXPOWER) begin
						res.kind = KIND_TXPOWER;
					end else if (st.ad_type == AD_TYPE_NAME) begin
						res.kind = KIND_NAMECHAR;
					end else begin
						res.kind = KIND_PAYLOAD;
					end
					res.adi           = st.ad_number;
					res.off           = st.pay_off;
					st_next.pay_off   = st.pay_off + 8'd1;
					st_next.ad_left   = al_dec;
					st_next.data_left = dl_dec;
					if (al_dec == 8'd0) begin
						if (dl_dec == 8'd0) begin
							st_next.phase = PH_RSSI;
						end else begin
							st_next.phase     = PH_ADLEN;
							st_next.ad_number = adn_inc;
						end
					end
				end
				PH_RSSI: begin
					res.kind              = KIND_RSSI;
					st_next.report_number = st.report_number + 8'd1;
					if (st.reports_left <= 8'd1) begin
						st_next.reports_left = 8'd0;
						res.done             = 1'b1;
						st_next.phase        = PH_WAIT;
					end else begin
						st_next.reports_left = st.reports_left - 8'd1;
						st_next.phase        = PH_ADVTYPE;
					end
				end
				default: begin
					// Stray byte outside an event: dropped without a result.
					res.has_result = 1'b0;
					st_next.phase  = PH_WAIT;
				end
			endcase
		end
	end
endmodule

[design/ble_adv_report_parser_core.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | data_byte, first_byte
// result   | out_valid / out_ready| field_kind, field_value, report_index,
//          |                      | ad_index, byte_offset, event_done, error_code
// config   | cfg_valid / cfg_ready| cfg_data (max_reports)
//
// One byte per cycle sustained while the result side does not stall; a byte's result
// passes the input register, then the result register, which offers it.
// The parse step is one pass of combinational logic between those registers.
// Reset clears the parser state and sets max_reports to 25; no clearing pass.
// A stall on the result side holds the result register and then the input
// register; the input side stalls only when both are full.
// A stray byte outside an event is consumed and gives no result.
module ble_adv_report_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] field_kind,
	output logic [7:0] field_value,
	output logic [7:0] report_index,
	output logic [6:0] ad_index,
	output logic [7:0] byte_offset,
	output logic       event_done,
	output logic [1:0] error_code,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import bleap_pkg::*;

	logic          vld_s1;
	logic [7:0]    data_s1;
	logic          first_s1;
	logic          advance;
	logic [7:0]    max_reports_q;
	parse_state_t  st_q;
	parse_state_t  st_next;
	parse_result_t res;

	// The input register drains when the result register is free.
	assign advance = vld_s1 && (!out_valid || out_ready);

	bleap_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.advance    (advance),
		.vld_s1     (vld_s1),
		.data_s1    (data_s1),
		.first_s1   (first_s1)
	);

	bleap_step u_step (
		.st          (st_q),
		.data        (data_s1),
		.first       (first_s1),
		.max_reports (max_reports_q),
		.st_next     (st_next),
		.res         (res)
	);

	// Configuration register; a write transaction is always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_reports_q <= MAX_REPORTS_RESET;
		end else if (cfg_valid) begin
			max_reports_q <= cfg_data;
		end
	end

	// Parser state advances once per byte leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res.has_result;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (advance && res.has_result) begin
			field_kind   <= res.kind;
			field_value  <= res.value;
			report_index <= res.rep;
			ad_index     <= res.adi;
			byte_offset  <= res.off;
			event_done   <= res.done;
			error_code   <= res.err;
		end
	end
endmodule

[design/bleap_checker.sv]
module bleap_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       first_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] field_kind,
	input logic [7:0] field_value,
	input logic [7:0] report_index,
	input logic [6:0] ad_index,
	input logic [7:0] byte_offset,
	input logic       event_done,
	input logic [1:0] error_code,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [7:0] cfg_data
);
	import bleap_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_kind)
			&& $stable(field_value) && $stable(error_code))
		else $error("result changed while stalled");

	// A count byte always opens at report zero.
	a_count_rep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == KIND_COUNT |-> report_index == 8'd0 && byte_offset == 8'd0)
		else $error("count byte with nonzero report index");

	// A count error only appears on the count byte.
	a_count_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_COUNT |-> field_kind == KIND_COUNT)
		else $error("count error on another field");

	// AD length errors only appear on AD length bytes.
	a_ad_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_ZERO_ADLEN || error_code == ERR_AD_OVERRUN)
		|-> field_kind == KIND_ADLEN)
		else $error("AD error on another field");

	// Event end is flagged only on an RSSI byte or an empty count byte.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_done |-> field_kind == KIND_RSSI
			|| (field_kind == KIND_COUNT && field_value == 8'd0))
		else $error("event end on wrong field");
endmodule

bind ble_adv_report_parser_core bleap_checker u_bleap_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import bleap_pkg::*;

	localparam int unsigned RANDOM_BYTES   = 200;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES  = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] field_kind;
	logic [7:0] field_value;
	logic [7:0] report_index;
	logic [6:0] ad_index;
	logic [7:0] byte_offset;
	logic       event_done;
	logic [1:0] error_code;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	// Predicted parser state and the register copy it uses.
	parse_state_t  parser = '0;
	logic [7:0]    max_reports_model = MAX_REPORTS_RESET;
	parse_result_t pending_tags[$];

	bit          steady = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned results_checked = 0;
	int unsigned events_done = 0;
	int unsigned error_flags = 0;
	int unsigned config_writes = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	ble_adv_report_parser_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_kind  (field_kind),
		.field_value (field_value),
		.report_index(report_index),
		.ad_index    (ad_index),
		.byte_offset (byte_offset),
		.event_done  (event_done),
		.error_code  (error_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	// An AD entry is complete: either another entry follows or the RSSI byte.
	task automatic close_ad_entry();
		if (parser.data_left == 8'd0) begin
			parser.phase = PH_RSSI;
		end else begin
			parser.phase = PH_ADLEN;
			if (parser.ad_number < AD_INDEX_MAX)
				parser.ad_number = parser.ad_number + 7'd1;
		end
	endtask

	// Tags one accepted byte and advances the predicted parser state.
	task automatic tag_byte(input logic [7:0] v, input logic first, output parse_result_t r);
		r = '0;
		r.has_result = 1'b1;
		r.value = v;
		r.rep = parser.report_number;
		if (first) begin
			// A count byte always opens a new event.
			r.kind = KIND_COUNT;
			r.rep = 8'd0;
			if (v == 8'd0 || v > max_reports_model)
				r.err = ERR_COUNT;
			parser.reports_left = v;
			parser.report_number = 8'd0;
			r.done = (v == 8'd0);
			parser.phase = (v == 8'd0) ? PH_WAIT : PH_ADVTYPE;
		end else begin
			case (parser.phase)
				PH_ADVTYPE: begin
					r.kind = KIND_ADVTYPE;
					parser.phase = PH_ADDRTYPE;
				end
				PH_ADDRTYPE: begin
					r.kind = KIND_ADDRTYPE;
					parser.addr_count = 3'd0;
					parser.phase = PH_ADDR;
				end
				PH_ADDR: begin
					r.kind = KIND_ADDR;
					r.off = {5'd0, parser.addr_count};
					if (parser.addr_count >= ADDR_LAST) begin
						parser.addr_count = 3'd0;
						parser.phase = PH_DATALEN;
					end else begin
						parser.addr_count = parser.addr_count + 3'd1;
					end
				end
				PH_DATALEN: begin
					r.kind = KIND_DATALEN;
					parser.data_left = v;
					parser.ad_number = 7'd0;
					parser.phase = (v == 8'd0) ? PH_RSSI : PH_ADLEN;
				end
				PH_ADLEN: begin
					r.kind = KIND_ADLEN;
					r.adi = parser.ad_number;
					parser.data_left = parser.data_left - 8'd1;
					if (v == 8'd0) begin
						r.err = ERR_ZERO_ADLEN;
						parser.ad_left = 8'd0;
						close_ad_entry();
					end else begin
						// An entry longer than the data left is cut to fit.
						if (v > parser.data_left) begin
							r.err = ERR_AD_OVERRUN;
							parser.ad_left = parser.data_left;
						end else begin
							parser.ad_left = v;
						end
						if (parser.ad_left == 8'd0)
							close_ad_entry();
						else
							parser.phase = PH_ADTYPE;
					end
				end
				PH_ADTYPE: begin
					r.kind = KIND_ADTYPE;
					r.adi = parser.ad_number;
					parser.ad_type = v;
					parser.ad_left = parser.ad_left - 8'd1;
					parser.data_left = parser.data_left - 8'd1;
					parser.pay_off = 8'd0;
					if (parser.ad_left == 8'd0)
						close_ad_entry();
					else
						parser.phase = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (parser.ad_type == AD_TYPE_TXPOWER)
						r.kind = KIND_TXPOWER;
					else if (parser.ad_type == AD_TYPE_NAME)
						r.kind = KIND_NAMECHAR;
					else
						r.kind = KIND_PAYLOAD;
					r.adi = parser.ad_number;
					r.off = parser.pay_off;
					parser.pay_off = parser.pay_off + 8'd1;
					parser.ad_left = parser.ad_left - 8'd1;
					parser.data_left = parser.data_left - 8'd1;
					if (parser.ad_left == 8'd0)
						close_ad_entry();
				end
				PH_RSSI: begin
					r.kind = KIND_RSSI;
					if (parser.reports_left > 8'd0)
						parser.reports_left = parser.reports_left - 8'd1;
					if (parser.reports_left == 8'd0) begin
						r.done = 1'b1;
						parser.phase = PH_WAIT;
					end else begin
						parser.phase = PH_ADVTYPE;
					end
					parser.report_number = parser.report_number + 8'd1;
				end
				default: begin
					// Stray byte outside an event: consumed, nothing tagged.
					parser.phase = PH_WAIT;
					r.has_result = 1'b0;
				end
			endcase
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Scoreboard: results are checked before the byte accepted at the same edge is tagged.
	always @(posedge clk) begin : scoreboard
		parse_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_tags.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d value %0d",
						$time, field_kind, field_value);
					mismatches++;
				end else begin
					want = pending_tags.pop_front();
					compare_field("field_kind", {4'd0, want.kind}, {4'd0, field_kind});
					compare_field("field_value", want.value, field_value);
					compare_field("report_index", want.rep, report_index);
					compare_field("ad_index", {1'b0, want.adi}, {1'b0, ad_index});
					compare_field("byte_offset", want.off, byte_offset);
					compare_field("event_done", {7'd0, want.done}, {7'd0, event_done});
					compare_field("error_code", {6'd0, want.err}, {6'd0, error_code});
					results_checked++;
					if (want.done)
						events_done++;
					if (want.err != ERR_NONE)
						error_flags++;
				end
			end
			if (in_valid && in_ready) begin
				tag_byte(data_byte, first_byte, want);
				if (want.has_result)
					pending_tags.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				max_reports_model = cfg_data;
		end
	end

	// The result side stalls at random unless a steady stretch is running.
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 22);

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results still expected",
				$time, quiet_cycles, pending_tags.size());
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one byte, with a random gap first, and returns at the edge that takes it.
	task automatic send_byte(input logic [7:0] v, input logic first);
		while (!steady && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= v;
		first_byte <= first;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_run(input logic [7:0] run[$]);
		foreach (run[i])
			send_byte(run[i], 1'b0);
	endtask

	// Waits until every expected result is in, then lets the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_max_reports(input logic [7:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		config_writes++;
	endtask

	// Count byte handling: zero count, stray bytes, restarts and an empty report.
	task automatic test_count_handling();
		send_byte(8'd0, 1'b1);
		send_byte(8'h5a, 1'b0);
		send_byte(MAX_REPORTS_RESET, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(MAX_REPORTS_RESET + 8'd1, 1'b1);
		send_byte(8'd1, 1'b1);
		send_run('{8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'h80});
		send_byte(8'hff, 1'b0);
	endtask

	// One report holding power, name, zero-length, generic and overrunning entries.
	task automatic test_ad_structures();
		send_byte(8'd1, 1'b1);
		send_run('{8'hff, 8'h00, 8'ha5, 8'h5a, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'd14});
		send_run('{8'd2, AD_TYPE_TXPOWER, 8'h80});
		send_run('{8'd3, AD_TYPE_NAME, 8'h41, 8'h7a});
		send_run('{8'd0});
		send_run('{8'd2, 8'hff, 8'h00});
		send_run('{8'd7, 8'h16, 8'h01});
		send_run('{8'h7f});
	endtask

	// Longest data block of zero-length entries drives the AD index into saturation.
	task automatic test_ad_index_limit();
		steady <= 1'b1;
		send_byte(8'd1, 1'b1);
		send_run('{8'h03, 8'h01, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'd255});
		repeat (254)
			send_byte(8'd0, 1'b0);
		// Last data byte claims more than is left, so the entry is empty.
		send_byte(8'd5, 1'b0);
		send_byte(8'hc0, 1'b0);
		steady <= 1'b0;
	endtask

	// Count limit register at its extremes and in between.
	task automatic test_max_reports();
		logic [7:0] limits[5];
		logic [7:0] counts[5];
		limits[0] = 8'd1;
		limits[1] = 8'd255;
		limits[2] = 8'd0;
		limits[3] = 8'($urandom_range(2, 254));
		limits[4] = MAX_REPORTS_RESET;
		foreach (limits[i]) begin
			write_max_reports(limits[i]);
			counts[0] = 8'd0;
			counts[1] = 8'd1;
			counts[2] = limits[i];
			counts[3] = limits[i] + 8'd1;
			counts[4] = 8'd255;
			foreach (counts[j])
				send_byte(counts[j], 1'b1);
			send_byte(8'h00, 1'b0);
		end
	endtask

	// Mostly well-formed events with random content, plus noise and cut-off events.
	task automatic test_random_traffic();
		logic [8:0]  stream[$];
		logic [7:0]  ad_kind;
		int unsigned start, events, n_rep, cnt, left, len, cut, pick;
		start = bytes_sent;
		events = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (events % 30 == 29)
				write_max_reports(8'($urandom_range(1, 255)));
			steady <= (events >= 12 && events < 24);
			stream.delete();
			if ($urandom_range(99) < 10)
				repeat ($urandom_range(1, 3))
					stream.push_back({1'b0, 8'($urandom())});
			pick = $urandom_range(99);
			if (pick < 10)
				cnt = 0;
			else if (pick < 20)
				cnt = $urandom_range(5, 255);
			else
				cnt = $urandom_range(1, 4);
			stream.push_back({1'b1, 8'(cnt)});
			n_rep = (cnt > 4) ? $urandom_range(0, 2) : cnt;
			repeat (n_rep) begin
				// Advert type, address type and the six address bytes.
				repeat (8)
					stream.push_back({1'b0, 8'($urandom())});
				left = ($urandom_range(99) < 5) ? $urandom_range(32, 255) : $urandom_range(0, 31);
				stream.push_back({1'b0, 8'(left)});
				while (left > 0) begin
					pick = $urandom_range(99);
					if (left == 1 || pick < 6) begin
						stream.push_back({1'b0, (left == 1) ? 8'($urandom()) : 8'd0});
						left = left - 1;
					end else if (pick < 12) begin
						// The length overruns, so the rest of the data forms the entry.
						stream.push_back({1'b0, 8'($urandom_range(left, 255))});
						repeat (left - 1)
							stream.push_back({1'b0, 8'($urandom())});
						left = 0;
					end else begin
						len = $urandom_range(1, (left - 1 < 12) ? left - 1 : 12);
						case ($urandom_range(3))
							0: ad_kind = AD_TYPE_TXPOWER;
							1: ad_kind = AD_TYPE_NAME;
							default: ad_kind = 8'($urandom());
						endcase
						stream.push_back({1'b0, 8'(len)});
						stream.push_back({1'b0, ad_kind});
						repeat (len - 1)
							stream.push_back({1'b0, 8'($urandom())});
						left = left - len - 1;
					end
				end
				stream.push_back({1'b0, 8'($urandom())});
			end
			// Now and then the event is cut short and the next count byte restarts it.
			if ($urandom_range(99) < 10) begin
				cut = $urandom_range(1, stream.size());
				while (stream.size() > cut)
					void'(stream.pop_back());
			end
			foreach (stream[i])
				send_byte(stream[i][7:0], stream[i][8]);
			events++;
		end
		steady <= 1'b0;
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		test_count_handling();
		test_ad_structures();
		test_ad_index_limit();
		test_max_reports();
		test_random_traffic();
		wait_idle();
		$display("Parsed %0d bytes into %0d checked results across %0d count-limit writes.",
			bytes_sent, results_checked, config_writes);
		$display("Saw %0d finished events and %0d flagged errors; %0d mismatches.",
			events_done, error_flags, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
design/bleap_pkg.sv
design/bleap_in_stage.sv
design/bleap_step.sv
design/ble_adv_report_parser_core.sv
design/bleap_checker.sv
tb/testbench.sv
